[hdl/tspn_pkg.sv]
// ----------------------------------------------------------------------------
// tspn_pkg
// Shared types, constants and cell arithmetic for the toy SPN block cipher.
// ----------------------------------------------------------------------------
package tspn_pkg;

   localparam int CELLS      = 16;
   localparam int SIDE       = 4;
   localparam int CELL_W     = 4;
   localparam int BLOCK_W    = CELLS * CELL_W;
   localparam int ROUNDS     = 9;
   localparam int KLEN_W     = 5;
   localparam int CSR_IDX_W  = 2;

   typedef logic [BLOCK_W-1:0]   block_type;
   typedef logic [KLEN_W-1:0]    klen_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SBOX_TABLE  = 2'd0,
      CSR_KEY_NIBBLES = 2'd1,
      CSR_KEY_LENGTH  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_addr_type;

   // per-cell add modulo 16 of an expanded round key
   function automatic block_type add_key(input block_type blk, input block_type ekey);
      block_type res;
      for (int i = 0; i < CELLS; i++) begin
         res[i*CELL_W +: CELL_W] = blk[i*CELL_W +: CELL_W] + ekey[i*CELL_W +: CELL_W];
      end
      return res;
   endfunction

endpackage

[hdl/tspn_key_expand.sv]
// ----------------------------------------------------------------------------
// tspn_key_expand
// Repeats the first key_length key nibbles over all sixteen cells.
// ----------------------------------------------------------------------------
module tspn_key_expand (
   input  tspn_pkg::block_type key_nibbles,
   input  tspn_pkg::klen_type  key_length,
   output tspn_pkg::block_type key_expanded
);
   import tspn_pkg::*;

   logic [3:0] len_sel;

   // zero acts as one, above sixteen saturates
   always_comb begin
      priority if (key_length == '0) begin
         len_sel = 4'd0;
      end else if (key_length[4] && (key_length[3:0] != 4'd0)) begin
         len_sel = 4'd15;
      end else begin
         len_sel = 4'(key_length - 5'd1);
      end
   end

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      logic [CELL_W-1:0] cand [CELLS];
      for (genvar k = 1; k <= CELLS; k++) begin : g_len
         localparam int SRC = c % k;
         assign cand[k-1] = key_nibbles[SRC*CELL_W +: CELL_W];
      end
      assign key_expanded[c*CELL_W +: CELL_W] = cand[len_sel];
   end

endmodule

[hdl/tspn_round.sv]
// ----------------------------------------------------------------------------
// tspn_round
// One cipher round: S-box on every cell, row r rotated left by r, key add.
// ----------------------------------------------------------------------------
module tspn_round (
   input  tspn_pkg::block_type blk_in,
   input  tspn_pkg::block_type sbox_table,
   input  tspn_pkg::block_type key_expanded,
   output tspn_pkg::block_type blk_out
);
   import tspn_pkg::*;

   block_type subst;
   block_type rot;

   for (genvar i = 0; i < CELLS; i++) begin : g_sub
      assign subst[i*CELL_W +: CELL_W] =
         sbox_table[blk_in[i*CELL_W +: CELL_W]*CELL_W +: CELL_W];
   end

   for (genvar r = 0; r < SIDE; r++) begin : g_row
      for (genvar c = 0; c < SIDE; c++) begin : g_col
         localparam int SRC = r * SIDE + ((c + r) % SIDE);
         assign rot[(r*SIDE + c)*CELL_W +: CELL_W] = subst[SRC*CELL_W +: CELL_W];
      end
   end

   assign blk_out = add_key(rot, key_expanded);

endmodule

[hdl/toy_spn_block_encrypt_core.sv]
// ----------------------------------------------------------------------------
// toy_spn_block_encrypt_core
// Toy 4x4 nibble SPN cipher, a key-add stage then one pipeline stage per round.
// rsp_valid and rsp_cipher_block come straight from the last round stage register.
// Throughput: one item per cycle while rsp_stall is low; each stage holds under stall, bubbles close.
// Reset: synchronous; clears stage valid bits, S-box and key to zero,
// key length to one.
// ----------------------------------------------------------------------------
module toy_spn_block_encrypt_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tspn_pkg::block_type   req_plain_block,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tspn_pkg::block_type   rsp_cipher_block,
   input  logic                  csr_wr_en,
   input  tspn_pkg::csr_idx_type csr_index,
   input  tspn_pkg::block_type   csr_wdata
);
   import tspn_pkg::*;

   block_type sbox_ff;
   block_type key_ff;
   klen_type  klen_ff;
   block_type key_exp;

   block_type data_ff  [ROUNDS+1];
   logic      valid_ff [ROUNDS+1];
   logic      ready    [ROUNDS+1];
   block_type round_out [ROUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sbox_ff <= '0;
         key_ff  <= '0;
         klen_ff <= klen_type'(1);
      end else if (csr_wr_en) begin
         unique case (csr_addr_type'(csr_index))
            CSR_SBOX_TABLE:  sbox_ff <= csr_wdata;
            CSR_KEY_NIBBLES: key_ff  <= csr_wdata;
            CSR_KEY_LENGTH:  klen_ff <= csr_wdata[KLEN_W-1:0];
            default: ;
         endcase
      end
   end

   tspn_key_expand u_key_expand (
      .key_nibbles  (key_ff),
      .key_length   (klen_ff),
      .key_expanded (key_exp)
   );

   always_comb begin
      ready[ROUNDS] = !valid_ff[ROUNDS] || !rsp_stall;
      for (int i = ROUNDS - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   for (genvar s = 0; s < ROUNDS; s++) begin : g_round
      tspn_round u_round (
         .blk_in       (data_ff[s]),
         .sbox_table   (sbox_ff),
         .key_expanded (key_exp),
         .blk_out      (round_out[s])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ROUNDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i <= ROUNDS; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         data_ff[0] <= add_key(req_plain_block, key_exp);
      end
      for (int i = 1; i <= ROUNDS; i++) begin
         if (ready[i]) begin
            data_ff[i] <= round_out[i-1];
         end
      end
   end

   assign req_stall        = !ready[0];
   assign rsp_valid        = valid_ff[ROUNDS];
   assign rsp_cipher_block = data_ff[ROUNDS];

endmodule

[hdl/tspn_checker.sv]
// ----------------------------------------------------------------------------
// tspn_checker
// Port-level checks for the cipher pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tspn_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input tspn_pkg::block_type   req_plain_block,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input tspn_pkg::block_type   rsp_cipher_block
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input backs up only when the output stage holds an item and the output is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a full, stalled pipeline");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cipher_block)))
      else $error("stalled result item changed");

   // a stalled input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_plain_block)))
      else $error("stalled input item changed");

endmodule

bind toy_spn_block_encrypt_core tspn_checker u_tspn_checker (.*);
